// ===== rtl/core/mbps_pkg.sv =====
// Shared types and constants for the masked byte pattern scanner.
// No dependencies; imported by mbps_cell and masked_byte_pattern_scanner.
`default_nettype none

package mbps_pkg;

  // Chain geometry and offset width
  localparam int MAX_PATTERN = 32;
  localparam int OFFSET_BITS = 32;
  localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);

  // Fixed widths of the register file and payload
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_LEN_W   = 6;
  localparam int ADDR_W      = 32;
  localparam int PAT_WORDS   = 4;
  localparam int PAT_BYTES   = 32;

  // Bytes equal to this are passed over once a candidate has started
  localparam logic [7:0] SKIP_BYTE = 8'hCC;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT0 = 3'd0,
    CFG_PAT1 = 3'd1,
    CFG_PAT2 = 3'd2,
    CFG_PAT3 = 3'd3,
    CFG_CARE = 3'd4,
    CFG_LEN  = 3'd5,
    CFG_BASE = 3'd6
  } cfg_idx_t;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  // Per-beat control broadcast to every cell
  typedef struct packed {
    logic       step;   // beat accepted and no match reported yet
    logic       clear;  // beat accepted and it closes the region
    logic       skip;   // data byte is the skip byte
    logic [7:0] data;   // data byte of the beat
  } cell_ctrl_t;

  // Per-cell view of the configuration
  typedef struct packed {
    logic       in_use; // cell position below the pattern length
    logic       last;   // cell position is the final pattern byte
    logic       care;   // compare this pattern byte
    logic [7:0] pat;    // pattern byte for this position
  } cell_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/mbps_cell.sv =====
// One cell of the candidate chain: holds the earliest partial match that
// has accepted a fixed number of pattern bytes. Depends on mbps_pkg.
`default_nettype none

module mbps_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  mbps_pkg::cell_ctrl_t ctrl,
  input  mbps_pkg::cell_cfg_t  cfg,
  input  wire                  prev_adv,
  input  mbps_pkg::offset_t    prev_start,
  output logic                 adv,
  output logic                 done,
  output logic                 valid,
  output mbps_pkg::offset_t    start
);
  import mbps_pkg::*;

  logic    valid_r, valid_nxt;
  offset_t start_r, start_nxt;
  logic    keep;
  logic    hit;
  logic    ok;

  // Compare this position against the data byte
  always_comb begin
    ok   = !cfg.care || (cfg.pat == ctrl.data);
    keep = ctrl.skip && valid_r && cfg.in_use;
    hit  = valid_r && cfg.in_use && !ctrl.skip && ok;
    adv  = hit && !cfg.last;
    done = hit && cfg.last;
  end

  // Clear at region end; on a step, hold over a skip byte, otherwise take the neighbor's advancing candidate
  always_comb begin
    valid_nxt = valid_r;
    start_nxt = start_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctrl.step) begin
      valid_nxt = keep || prev_adv;
      start_nxt = keep ? start_r : prev_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
  end

  assign valid = valid_r;
  assign start = start_r;

endmodule

`default_nettype wire

// ===== rtl/core/masked_byte_pattern_scanner.sv =====
// Top level of the masked byte pattern scanner: register file, start
// injector, chain of mbps_cell instances and result register. Uses mbps_pkg.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_data_byte,        | to block
//           | in_region_end                            |
//   out     | out_valid, out_stall, out_found,         | from block
//           | out_match_address                        |
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata          | to block
//
// One byte per cycle: until a match is reported, the chain advances in the
// cycle a beat is accepted, and the result of that beat is registered on
// the same edge. in_stall rises only while a result sits in the output
// register and the sink stalls it; any other cycle a new beat is taken.
// Reset (synchronous, rst_n low) clears chain and offset, presets config.
`default_nettype none

module masked_byte_pattern_scanner (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [7:0]                        in_data_byte,
  input  wire                               in_region_end,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              out_found,
  output logic [mbps_pkg::ADDR_W-1:0]       out_match_address,
  input  wire                               cfg_wr_en,
  input  wire  [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [mbps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mbps_pkg::*;

  // Configuration registers
  logic [CFG_DATA_W-1:0] pat_r [PAT_WORDS];
  logic [PAT_BYTES-1:0]  care_r;
  logic [CFG_LEN_W-1:0]  len_r;
  logic [ADDR_W-1:0]     base_r;

  // Scan state
  offset_t               byte_offset_r, byte_offset_nxt;
  logic                  match_reported_r, match_reported_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [ADDR_W-1:0]     out_addr_r, out_addr_nxt;

  logic [PAT_BYTES*8-1:0] pat_flat;
  logic [LEN_BITS-1:0]    len_used;
  logic                   acc;
  logic                   load_out;
  logic                   hit0;
  logic                   done0;
  logic                   done_any;
  offset_t                done_start;
  cell_ctrl_t             ctrl;

  logic [MAX_PATTERN-1:0] adv_vec;
  logic [MAX_PATTERN-1:0] done_vec;
  logic [MAX_PATTERN-1:0] valid_vec;
  offset_t                start_vec [MAX_PATTERN];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < PAT_WORDS; w++) begin
        pat_r[w] <= '0;
      end
      care_r <= '1;
      len_r  <= CFG_LEN_W'(1);
      base_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PAT0: pat_r[0] <= cfg_wdata;
        CFG_PAT1: pat_r[1] <= cfg_wdata;
        CFG_PAT2: pat_r[2] <= cfg_wdata;
        CFG_PAT3: pat_r[3] <= cfg_wdata;
        CFG_CARE: care_r   <= cfg_wdata[PAT_BYTES-1:0];
        CFG_LEN:  len_r    <= cfg_wdata[CFG_LEN_W-1:0];
        CFG_BASE: base_r   <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_flat = {pat_r[3], pat_r[2], pat_r[1], pat_r[0]};

  // Clamp the pattern length into 1..MAX_PATTERN
  always_comb begin
    if (len_r == '0) begin
      len_used = LEN_BITS'(1);
    end else if (len_r > CFG_LEN_W'(MAX_PATTERN)) begin
      len_used = LEN_BITS'(MAX_PATTERN);
    end else begin
      len_used = len_r[LEN_BITS-1:0];
    end
  end

  // Handshake: take a beat unless a result is parked and stalled
  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    ctrl.step  = acc && !match_reported_r;
    ctrl.clear = acc && in_region_end;
    ctrl.skip  = (in_data_byte == SKIP_BYTE);
    ctrl.data  = in_data_byte;
  end

  // Start injector: pattern byte 0 opens a candidate at the current offset
  assign hit0         = (in_data_byte == pat_flat[7:0]);
  assign done0        = hit0 && (len_used == LEN_BITS'(1));
  assign adv_vec[0]   = hit0 && (len_used != LEN_BITS'(1));
  assign done_vec[0]  = done0;
  assign valid_vec[0] = 1'b0;
  assign start_vec[0] = byte_offset_r;

  // Chain of candidate cells, one per pattern position after the first
  for (genvar p = 1; p < MAX_PATTERN; p++) begin : g_cell
    cell_cfg_t cfg_p;

    always_comb begin
      cfg_p.in_use = (LEN_BITS'(p) < len_used);
      cfg_p.last   = (LEN_BITS'(p) == len_used - LEN_BITS'(1));
      cfg_p.care   = care_r[p];
      cfg_p.pat    = pat_flat[p*8 +: 8];
    end

    mbps_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .cfg        (cfg_p),
      .prev_adv   (adv_vec[p-1]),
      .prev_start (start_vec[p-1]),
      .adv        (adv_vec[p]),
      .done       (done_vec[p]),
      .valid      (valid_vec[p]),
      .start      (start_vec[p])
    );
  end

  // Pick the start of the completing candidate (at most one completes)
  always_comb begin
    done_start = '0;
    for (int p = 0; p < MAX_PATTERN; p++) begin
      done_start = done_start | ({OFFSET_BITS{done_vec[p]}} & start_vec[p]);
    end
    done_any = |done_vec;
  end

  // Advance offset and match flag; region end returns both to reset
  always_comb begin
    byte_offset_nxt    = byte_offset_r;
    match_reported_nxt = match_reported_r;
    if (acc) begin
      if (in_region_end) begin
        byte_offset_nxt    = '0;
        match_reported_nxt = 1'b0;
      end else begin
        byte_offset_nxt = byte_offset_r + OFFSET_BITS'(1);
        if (!match_reported_r && done_any) begin
          match_reported_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r    <= '0;
      match_reported_r <= 1'b0;
    end else begin
      byte_offset_r    <= byte_offset_nxt;
      match_reported_r <= match_reported_nxt;
    end
  end

  // Load the result register on a match or at region end, drop when taken
  assign load_out = acc && !match_reported_r && (done_any || in_region_end);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = done_any;
      out_addr_nxt  = done_any ? (base_r + ADDR_W'(done_start)) : '0;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

`ifndef SYNTHESIS
  // At most one candidate may complete on a beat
  a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(done_vec))
    else $error("more than one candidate completed on one beat");

  // The top cell never advances
  a_top_no_adv: assert property (@(posedge clk) disable iff (!rst_n)
    !adv_vec[MAX_PATTERN-1])
    else $error("top cell advanced past the chain");

  // Region end leaves the scan in its reset state
  a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_region_end |=>
      (valid_vec == '0) && (byte_offset_r == '0) && !match_reported_r)
    else $error("scan state not cleared after region end");

  // Once a match is reported, no further result in this region
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    match_reported_r |-> !load_out)
    else $error("second result loaded in one region");
`endif

endmodule

`default_nettype wire
